@@ sv/psd_pkg.sv @@
// ============================================================================
// psd_pkg: shared types and constants for the point-segment distance core
// Holds the transaction structs, the clamp codes, the internal widths and the
// split-square helpers used by the datapath stages.
// ============================================================================
package psd_pkg;

  // Coordinate and configuration width.
  localparam int CW = 32;
  // Coordinate differences (signed) and their magnitudes.
  localparam int DFW = 33;
  localparam int MW = 32;
  // Products of two magnitudes and sums of three such products.
  localparam int PW = 64;
  localparam int LW = 66;
  // Rounded-division operands: numerator, divisor, remainder, quotient.
  localparam int NW = 100;
  localparam int DVW = 67;
  localparam int RW = 101;
  localparam int QW = 34;
  // Signed foot offsets and derived differences.
  localparam int OFW = 36;
  // Square helper: operand magnitude, half width, square, sum of squares.
  localparam int XW = 36;
  localparam int HW = 18;
  localparam int SQW = 72;
  localparam int SSW = 74;
  // Square root: root bits and remainder width.
  localparam int SRW = 37;
  localparam int SREMW = 76;
  // Result widths.
  localparam int DISTW = 35;
  localparam int KW = 2;
  // Margin is scaled up to 32 fraction bits before the clamp compare.
  localparam int MARGIN_SHIFT = 16;

  typedef enum logic [KW-1:0] {
    KIND_FOOT  = 2'd0,
    KIND_START = 2'd1,
    KIND_END   = 2'd2
  } kind_t;

  typedef struct packed {
    logic signed [CW-1:0] start_x;
    logic signed [CW-1:0] start_y;
    logic signed [CW-1:0] start_z;
    logic signed [CW-1:0] end_x;
    logic signed [CW-1:0] end_y;
    logic signed [CW-1:0] end_z;
    logic signed [CW-1:0] query_x;
    logic signed [CW-1:0] query_y;
    logic signed [CW-1:0] query_z;
  } in_item_t;

  typedef struct packed {
    logic [DISTW-1:0] distance;
    logic [KW-1:0]    clamp_kind;
  } out_item_t;

  // Partial products of one square, split at HW bits.
  typedef struct packed {
    logic [2*HW-1:0] hh;
    logic [2*HW-1:0] hl;
    logic [2*HW-1:0] ll;
  } sq_parts_t;

  function automatic sq_parts_t sq_split(input logic [XW-1:0] x);
    sq_parts_t p;
    p.hh = x[XW-1:HW] * x[XW-1:HW];
    p.hl = x[XW-1:HW] * x[HW-1:0];
    p.ll = x[HW-1:0] * x[HW-1:0];
    return p;
  endfunction

  function automatic logic [SQW-1:0] sq_join(input sq_parts_t p);
    logic [SQW-1:0] s;
    s = (SQW'(p.hh) << (2 * HW)) + (SQW'(p.hl) << (HW + 1)) + SQW'(p.ll);
    return s;
  endfunction

endpackage

@@ sv/point_segment_distance_core.sv @@
// ============================================================================
// point_segment_distance_core: streaming 3D point-to-segment distance
// Projects a query point onto the line through a segment, clamps the foot to
// an endpoint when it falls outside the segment, and returns the distance.
// ============================================================================
//
//  Channel  | Signals                          | Direction | Transaction
//  ---------+----------------------------------+-----------+-------------------
//  input    | in_valid, in_ready, in_item      | in        | A, B and Q coords
//  output   | out_valid, out_ready, out_item   | out       | distance and kind
//  config   | cfg_we, cfg_wdata                | in        | distance_margin
//
// One transaction enters per cycle while the skid is empty. Between an input
// and its result lie 6 setup stages, 34 division steps (one quotient bit each),
// 7 clamp and square stages, 37 square-root steps (one root bit each) and the
// output register. Reset clears every valid bit and the margin.
// A two-entry output (output register plus skid register) lets the pipeline
// advance while a result waits; the pipeline freezes only while both are full.
//
module point_segment_distance_core
  import psd_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  in_item_t      in_item,
  output logic          out_valid,
  input  logic          out_ready,
  output out_item_t     out_item,
  input  logic          cfg_we,
  input  logic [CW-1:0] cfg_wdata
);

  // Stage count of the valid chain, ending at the last square-root step.
  localparam int NST = 13 + QW + SRW;

  logic [CW-1:0]  margin;
  logic [NST-1:0] vld;
  logic           skid_v;
  out_item_t      skid_item;
  out_item_t      res;
  logic           en;

  // The whole pipeline moves together; it holds only when the skid is full.
  assign en = !skid_v;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      margin <= '0;
    end else if (cfg_we) begin
      margin <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], in_valid};
    end
  end

  // --------------------------------------------------------------------------
  // Stage 0: segment vector AB = B - A and query vector AQ = Q - A.
  // --------------------------------------------------------------------------
  logic signed [CW-1:0]  pa [3];
  logic signed [CW-1:0]  pb [3];
  logic signed [CW-1:0]  pq [3];
  logic signed [DFW-1:0] s0_ab [3];
  logic signed [DFW-1:0] s0_aq [3];

  always_comb begin
    pa[0] = in_item.start_x;
    pa[1] = in_item.start_y;
    pa[2] = in_item.start_z;
    pb[0] = in_item.end_x;
    pb[1] = in_item.end_y;
    pb[2] = in_item.end_z;
    pq[0] = in_item.query_x;
    pq[1] = in_item.query_y;
    pq[2] = in_item.query_z;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s0_ab[i] <= DFW'(pb[i]) - DFW'(pa[i]);
        s0_aq[i] <= DFW'(pq[i]) - DFW'(pa[i]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: magnitudes and the per-axis products for |AB|^2 and AQ . AB.
  // Both differences stay below 2^32 in magnitude.
  // --------------------------------------------------------------------------
  logic [DFW-1:0]        ab_abs [3];
  logic [DFW-1:0]        aq_abs [3];
  logic [PW-1:0]         s1_sq [3];
  logic [PW-1:0]         s1_pr [3];
  logic                  s1_sg [3];
  logic [MW-1:0]         s1_mab [3];
  logic signed [DFW-1:0] s1_ab [3];
  logic signed [DFW-1:0] s1_aq [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ab_abs[i] = s0_ab[i][DFW-1] ? DFW'(-s0_ab[i]) : DFW'(s0_ab[i]);
      aq_abs[i] = s0_aq[i][DFW-1] ? DFW'(-s0_aq[i]) : DFW'(s0_aq[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1_sq[i] <= ab_abs[i][MW-1:0] * ab_abs[i][MW-1:0];
        s1_pr[i] <= ab_abs[i][MW-1:0] * aq_abs[i][MW-1:0];
        s1_sg[i] <= s0_ab[i][DFW-1] ^ s0_aq[i][DFW-1];
        s1_mab[i] <= ab_abs[i][MW-1:0];
        s1_ab[i] <= s0_ab[i];
        s1_aq[i] <= s0_aq[i];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: squared length L and the dot product kept as positive and
  // negative partial sums.
  // --------------------------------------------------------------------------
  logic [LW-1:0]         pos_sum;
  logic [LW-1:0]         neg_sum;
  logic [LW-1:0]         s2_len;
  logic [LW-1:0]         s2_pos;
  logic [LW-1:0]         s2_neg;
  logic [MW-1:0]         s2_mab [3];
  logic signed [DFW-1:0] s2_ab [3];
  logic signed [DFW-1:0] s2_aq [3];

  always_comb begin
    pos_sum = '0;
    neg_sum = '0;
    for (int i = 0; i < 3; i++) begin
      if (s1_sg[i]) begin
        neg_sum = neg_sum + LW'(s1_pr[i]);
      end else begin
        pos_sum = pos_sum + LW'(s1_pr[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_len <= LW'(s1_sq[0]) + LW'(s1_sq[1]) + LW'(s1_sq[2]);
      s2_pos <= pos_sum;
      s2_neg <= neg_sum;
      for (int i = 0; i < 3; i++) begin
        s2_mab[i] <= s1_mab[i];
        s2_ab[i] <= s1_ab[i];
        s2_aq[i] <= s1_aq[i];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: sign and magnitude of the dot product D.
  // --------------------------------------------------------------------------
  logic                  s3_dneg;
  logic [LW-1:0]         s3_dm;
  logic [LW-1:0]         s3_len;
  logic [MW-1:0]         s3_mab [3];
  logic signed [DFW-1:0] s3_ab [3];
  logic signed [DFW-1:0] s3_aq [3];

  always_ff @(posedge clk) begin
    if (en) begin
      s3_dneg <= s2_pos < s2_neg;
      s3_dm <= (s2_pos < s2_neg) ? (s2_neg - s2_pos) : (s2_pos - s2_neg);
      s3_len <= s2_len;
      for (int i = 0; i < 3; i++) begin
        s3_mab[i] <= s2_mab[i];
        s3_ab[i] <= s2_ab[i];
        s3_aq[i] <= s2_aq[i];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: |D| * |AB_i| as two partial products on the halves of |D|.
  // --------------------------------------------------------------------------
  logic [DFW+MW-1:0]     s4_pl [3];
  logic [DFW+MW-1:0]     s4_ph [3];
  logic                  s4_dneg;
  logic [LW-1:0]         s4_len;
  logic signed [DFW-1:0] s4_ab [3];
  logic signed [DFW-1:0] s4_aq [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s4_pl[i] <= s3_dm[DFW-1:0] * s3_mab[i];
        s4_ph[i] <= s3_dm[LW-1:DFW] * s3_mab[i];
        s4_ab[i] <= s3_ab[i];
        s4_aq[i] <= s3_aq[i];
      end
      s4_dneg <= s3_dneg;
      s4_len <= s3_len;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5 and the division pipeline. Each foot offset is |D| |AB_i| / L
  // rounded to nearest, computed as (2 N + L) / (2 L) with one quotient bit
  // per stage. Index 0 of the arrays below is the stage 5 register.
  // --------------------------------------------------------------------------
  logic [NW-1:0]         num [3];
  logic [NW-1:0]         numer [3];
  logic [RW-1:0]         dv_rem [QW+1][3];
  logic [QW-1:0]         dv_quo [QW+1][3];
  logic signed [DFW-1:0] dv_ab [QW+1][3];
  logic signed [DFW-1:0] dv_aq [QW+1][3];
  logic                  dv_sg [QW+1][3];
  logic [LW-1:0]         dv_len [QW+1];
  logic                  dv_lz [QW+1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i] = (NW'(s4_ph[i]) << DFW) + NW'(s4_pl[i]);
      numer[i] = (num[i] << 1) + NW'(s4_len);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dv_rem[0][i] <= RW'(numer[i]);
        dv_quo[0][i] <= '0;
        dv_ab[0][i] <= s4_ab[i];
        dv_aq[0][i] <= s4_aq[i];
        dv_sg[0][i] <= s4_ab[i][DFW-1] ^ s4_dneg;
      end
      dv_len[0] <= s4_len;
      dv_lz[0] <= (s4_len == '0);
      // Sideband follows the division steps stage for stage.
      for (int k = 0; k < QW; k++) begin
        for (int i = 0; i < 3; i++) begin
          dv_ab[k+1][i] <= dv_ab[k][i];
          dv_aq[k+1][i] <= dv_aq[k][i];
          dv_sg[k+1][i] <= dv_sg[k][i];
        end
        dv_len[k+1] <= dv_len[k];
        dv_lz[k+1] <= dv_lz[k];
      end
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    for (genvar i = 0; i < 3; i++) begin : g_axis
      psd_div_step #(
        .BIT(QW - 1 - k)
      ) u_step (
        .clk     (clk),
        .en      (en),
        .divisor ({dv_len[k], 1'b0}),
        .rem_in  (dv_rem[k][i]),
        .quo_in  (dv_quo[k][i]),
        .rem_out (dv_rem[k+1][i]),
        .quo_out (dv_quo[k+1][i])
      );
    end
  end

  // --------------------------------------------------------------------------
  // P1: signed foot offset AP, the vector BP = AP - AB and the unclamped
  // distance vector AQ - AP. A degenerate segment puts the foot on A.
  // --------------------------------------------------------------------------
  logic signed [OFW-1:0] off_c [3];
  logic signed [OFW-1:0] p1_off [3];
  logic signed [OFW-1:0] p1_e [3];
  logic signed [OFW-1:0] p1_c0 [3];
  logic signed [DFW-1:0] p1_ab [3];
  logic signed [DFW-1:0] p1_aq [3];
  logic [LW-1:0]         p1_len;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dv_lz[QW]) begin
        off_c[i] = '0;
      end else if (dv_sg[QW][i]) begin
        off_c[i] = -$signed(OFW'(dv_quo[QW][i]));
      end else begin
        off_c[i] = $signed(OFW'(dv_quo[QW][i]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p1_off[i] <= off_c[i];
        p1_e[i] <= off_c[i] - OFW'(dv_ab[QW][i]);
        p1_c0[i] <= OFW'(dv_aq[QW][i]) - off_c[i];
        p1_ab[i] <= dv_ab[QW][i];
        p1_aq[i] <= dv_aq[QW][i];
      end
      p1_len <= dv_len[QW];
    end
  end

  // --------------------------------------------------------------------------
  // P2: partial products of |AP_i|^2 and |BP_i|^2.
  // --------------------------------------------------------------------------
  logic [XW-1:0]         off_mag [3];
  logic [XW-1:0]         e_mag [3];
  sq_parts_t             p2_po [3];
  sq_parts_t             p2_pe [3];
  logic signed [OFW-1:0] p2_c0 [3];
  logic signed [DFW-1:0] p2_ab [3];
  logic signed [DFW-1:0] p2_aq [3];
  logic [LW-1:0]         p2_len;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      off_mag[i] = p1_off[i][OFW-1] ? XW'(-p1_off[i]) : XW'(p1_off[i]);
      e_mag[i] = p1_e[i][OFW-1] ? XW'(-p1_e[i]) : XW'(p1_e[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p2_po[i] <= sq_split(off_mag[i]);
        p2_pe[i] <= sq_split(e_mag[i]);
        p2_c0[i] <= p1_c0[i];
        p2_ab[i] <= p1_ab[i];
        p2_aq[i] <= p1_aq[i];
      end
      p2_len <= p1_len;
    end
  end

  // --------------------------------------------------------------------------
  // P3: squared distances |AP|^2 and |BP|^2.
  // --------------------------------------------------------------------------
  logic [SSW-1:0]        p3_sa;
  logic [SSW-1:0]        p3_sb;
  logic signed [OFW-1:0] p3_c0 [3];
  logic signed [DFW-1:0] p3_ab [3];
  logic signed [DFW-1:0] p3_aq [3];
  logic [LW-1:0]         p3_len;

  always_ff @(posedge clk) begin
    if (en) begin
      p3_sa <= SSW'(sq_join(p2_po[0])) + SSW'(sq_join(p2_po[1]))
             + SSW'(sq_join(p2_po[2]));
      p3_sb <= SSW'(sq_join(p2_pe[0])) + SSW'(sq_join(p2_pe[1]))
             + SSW'(sq_join(p2_pe[2]));
      for (int i = 0; i < 3; i++) begin
        p3_c0[i] <= p2_c0[i];
        p3_ab[i] <= p2_ab[i];
        p3_aq[i] <= p2_aq[i];
      end
      p3_len <= p2_len;
    end
  end

  // --------------------------------------------------------------------------
  // P4: clamp test. The foot lies off the segment when |AP|^2 + |BP|^2
  // exceeds L plus the margin; the endpoint nearer the foot is then used,
  // with a tie going to the start point.
  // --------------------------------------------------------------------------
  logic [SSW-1:0]        lim;
  logic [SSW:0]          tot;
  kind_t                 kind_c;
  kind_t                 p4_kind;
  logic signed [OFW-1:0] p4_c0 [3];
  logic signed [DFW-1:0] p4_ab [3];
  logic signed [DFW-1:0] p4_aq [3];

  always_comb begin
    lim = SSW'(p3_len) + (SSW'(margin) << MARGIN_SHIFT);
    tot = (SSW+1)'(p3_sa) + (SSW+1)'(p3_sb);
    if (tot > (SSW+1)'(lim)) begin
      kind_c = (p3_sa > p3_sb) ? KIND_END : KIND_START;
    end else begin
      kind_c = KIND_FOOT;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p4_kind <= kind_c;
      for (int i = 0; i < 3; i++) begin
        p4_c0[i] <= p3_c0[i];
        p4_ab[i] <= p3_ab[i];
        p4_aq[i] <= p3_aq[i];
      end
    end
  end

  // --------------------------------------------------------------------------
  // P5: distance vector from the chosen point to Q.
  // --------------------------------------------------------------------------
  logic signed [OFW-1:0] p5_dv [3];
  kind_t                 p5_kind;

  always_ff @(posedge clk) begin
    if (en) begin
      p5_kind <= p4_kind;
      for (int i = 0; i < 3; i++) begin
        case (p4_kind)
          KIND_START: begin
            p5_dv[i] <= OFW'(p4_aq[i]);
          end
          KIND_END: begin
            p5_dv[i] <= OFW'(p4_aq[i]) - OFW'(p4_ab[i]);
          end
          default: begin
            p5_dv[i] <= p4_c0[i];
          end
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // P6 and P7: squared distance, which then seeds the square-root pipeline.
  // --------------------------------------------------------------------------
  logic [XW-1:0]    dv_mag [3];
  sq_parts_t        p6_pd [3];
  kind_t            p6_kind;
  logic [SREMW-1:0] sq_rem [SRW+1];
  logic [SRW-1:0]   sq_root [SRW+1];
  kind_t            sq_kind [SRW+1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dv_mag[i] = p5_dv[i][OFW-1] ? XW'(-p5_dv[i]) : XW'(p5_dv[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p6_pd[i] <= sq_split(dv_mag[i]);
      end
      p6_kind <= p5_kind;
      sq_rem[0] <= SREMW'(sq_join(p6_pd[0])) + SREMW'(sq_join(p6_pd[1]))
                 + SREMW'(sq_join(p6_pd[2]));
      sq_root[0] <= '0;
      sq_kind[0] <= p6_kind;
      for (int k = 0; k < SRW; k++) begin
        sq_kind[k+1] <= sq_kind[k];
      end
    end
  end

  for (genvar k = 0; k < SRW; k++) begin : g_sqrt
    psd_sqrt_step #(
      .BIT(SRW - 1 - k)
    ) u_step (
      .clk      (clk),
      .en       (en),
      .rem_in   (sq_rem[k]),
      .root_in  (sq_root[k]),
      .rem_out  (sq_rem[k+1]),
      .root_out (sq_root[k+1])
    );
  end

  // --------------------------------------------------------------------------
  // Result: floor square root, saturated to the distance field.
  // --------------------------------------------------------------------------
  always_comb begin
    if (sq_root[SRW][SRW-1:DISTW] != '0) begin
      res.distance = '1;
    end else begin
      res.distance = sq_root[SRW][DISTW-1:0];
    end
    res.clamp_kind = sq_kind[SRW];
  end

  // Output register with a skid register behind it. A result leaving the
  // pipeline while the output is held parks in the skid, which then freezes
  // the pipeline until the output transaction completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_v <= 1'b0;
    end else if (out_ready || !out_valid) begin
      if (skid_v) begin
        out_valid <= 1'b1;
        skid_v <= 1'b0;
      end else begin
        out_valid <= vld[NST-1];
      end
    end else if (en && vld[NST-1]) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_valid) begin
      out_item <= skid_v ? skid_item : res;
    end else if (en && vld[NST-1]) begin
      skid_item <= res;
    end
  end

endmodule

@@ sv/psd_div_step.sv @@
// ============================================================================
// psd_div_step: one registered restoring-division step
// Tries to subtract the divisor shifted to quotient bit BIT and records the
// outcome in that quotient bit.
// ============================================================================
module psd_div_step
  import psd_pkg::*;
#(
  parameter int BIT = 0
) (
  input  logic           clk,
  input  logic           en,
  input  logic [DVW-1:0] divisor,
  input  logic [RW-1:0]  rem_in,
  input  logic [QW-1:0]  quo_in,
  output logic [RW-1:0]  rem_out,
  output logic [QW-1:0]  quo_out
);

  logic [RW-1:0] trial;
  logic [RW:0]   diff;
  logic          fits;
  logic [QW-1:0] quo_next;

  always_comb begin
    trial = RW'(divisor) << BIT;
    diff = {1'b0, rem_in} - {1'b0, trial};
    fits = !diff[RW];
    quo_next = quo_in;
    quo_next[BIT] = fits;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out <= fits ? diff[RW-1:0] : rem_in;
      quo_out <= quo_next;
    end
  end

endmodule

@@ sv/psd_sqrt_step.sv @@
// ============================================================================
// psd_sqrt_step: one registered step of the bit-by-bit integer square root
// Decides root bit BIT from the running remainder and the partial root.
// ============================================================================
module psd_sqrt_step
  import psd_pkg::*;
#(
  parameter int BIT = 0
) (
  input  logic             clk,
  input  logic             en,
  input  logic [SREMW-1:0] rem_in,
  input  logic [SRW-1:0]   root_in,
  output logic [SREMW-1:0] rem_out,
  output logic [SRW-1:0]   root_out
);

  logic [SREMW-1:0] trial;
  logic [SREMW:0]   diff;
  logic             fits;
  logic [SRW-1:0]   root_next;

  // Adding bit BIT to root r grows r^2 by r * 2^(BIT+1) + 2^(2*BIT).
  always_comb begin
    trial = (SREMW'(root_in) << (BIT + 1)) + (SREMW'(1) << (2 * BIT));
    diff = {1'b0, rem_in} - {1'b0, trial};
    fits = !diff[SREMW];
    root_next = root_in;
    root_next[BIT] = fits;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out <= fits ? diff[SREMW-1:0] : rem_in;
      root_out <= root_next;
    end
  end

endmodule
